@@ rtl/core/pwsd_pkg.sv @@
// Package for the pulse-width sensor decoder: field widths, register indexes,
// status codes, frame timing constants and the structs passed between modules.
// No dependencies.
package pwsd_pkg;

   // Field widths
   localparam int TIME_W   = 32;
   localparam int GAP_W    = 16;
   localparam int COUNT_W  = 5;
   localparam int STROBE_W = 8;
   localparam int WORD_W   = 16;
   localparam int CODE_W   = 11;
   localparam int TEMP_W   = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Conversion datapath widths
   localparam int PROD_W = 27;   // code * scale + half, below 2^27
   localparam int SUM_W  = 28;
   localparam int QUOT_W = 16;

   // Register reset values
   localparam logic [GAP_W-1:0]  GAP_RESET     = GAP_W'(500);
   localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(100000);

   // Frame timing
   localparam logic [COUNT_W-1:0] STROBE_EDGE = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] STOP_EDGE   = COUNT_W'(11);
   localparam logic [COUNT_W-1:0] LATCH_EDGE  = COUNT_W'(19);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(31);

   // Scaling: round(code * span / 2047) - offset, all in Q8 degrees
   localparam int FULL_SCALE = 2047;
   localparam int HALF_SCALE = FULL_SCALE / 2;
   localparam int SPAN_WIDE  = 200 * 256;
   localparam int SPAN_NAR   = 70 * 256;
   localparam int OFF_WIDE   = 50 * 256;
   localparam int OFF_NAR    = 10 * 256;

   // Item kinds
   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_POLL = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODEL_RANGE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_US      = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_US  = CSR_IDX_W'(2);

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NONE   = 2'd1,
      ST_LOST   = 2'd2,
      ST_PARITY = 2'd3
   } status_type;

   // Register write as seen by the tracker
   typedef struct packed {
      logic                  valid;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   // Poll outcome handed to the conversion pipeline
   typedef struct packed {
      status_type        status;
      logic [CODE_W-1:0] code;
      logic              range;
   } poll_type;

endpackage

@@ rtl/core/pwsd_if.sv @@
// Channel interfaces of the pulse-width sensor decoder: request, response and
// register write channels, each with valid/ready. Depends on pwsd_pkg.

interface pwsd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [pwsd_pkg::TIME_W-1:0]   time_us;

   modport source (output valid, output kind, output time_us, input ready);
   modport sink   (input valid, input kind, input time_us, output ready);
endinterface

interface pwsd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic signed [pwsd_pkg::TEMP_W-1:0] temperature_q8;

   modport source (output valid, output status, output temperature_q8, input ready);
   modport sink   (input valid, input status, input temperature_q8, output ready);
endinterface

interface pwsd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pwsd_pkg::CSR_IDX_W-1:0]    index;
   logic [pwsd_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/pwsd_track.sv @@
// Frame tracker: configuration registers, edge timing, bit shifting, word
// latch and the poll decision. Depends on pwsd_pkg.
module pwsd_track (
   input  logic                           clock,
   input  logic                           reset,
   input  pwsd_pkg::csr_write_type        csr_wr,
   input  logic                           accept,
   input  logic                           kind,
   input  logic [pwsd_pkg::TIME_W-1:0]    time_us,
   output logic                           poll_valid,
   output pwsd_pkg::poll_type             poll
);

   // Configuration
   logic                              range_ff, range_in;
   logic [pwsd_pkg::GAP_W-1:0]        gap_ff, gap_in;
   logic [pwsd_pkg::TIME_W-1:0]       timeout_ff, timeout_in;

   // Frame state
   logic [pwsd_pkg::TIME_W-1:0]       last_ff, last_in;
   logic [pwsd_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [pwsd_pkg::STROBE_W-1:0]     strobe_ff, strobe_in;
   logic [pwsd_pkg::WORD_W-1:0]       shift_ff, shift_in;
   logic [pwsd_pkg::WORD_W-1:0]       ready_ff, ready_in;

   logic [pwsd_pkg::TIME_W-1:0]       delta;
   logic [pwsd_pkg::COUNT_W-1:0]      count_inc;
   logic [pwsd_pkg::STROBE_W-1:0]     thr;
   logic [pwsd_pkg::WORD_W-1:0]       shifted;
   logic                              bit_early;
   logic                              parity_bad;
   logic                              is_edge;
   logic                              is_poll;

   assign is_edge = accept && (kind == pwsd_pkg::KIND_EDGE);
   assign is_poll = accept && (kind == pwsd_pkg::KIND_POLL);
   assign delta   = time_us - last_ff;

   // Register writes; unknown index is dropped
   always_comb begin
      range_in   = range_ff;
      gap_in     = gap_ff;
      timeout_in = timeout_ff;
      if (csr_wr.valid) begin
         case (csr_wr.index)
            pwsd_pkg::CSR_MODEL_RANGE: range_in   = csr_wr.data[0];
            pwsd_pkg::CSR_GAP_US:      gap_in     = csr_wr.data[pwsd_pkg::GAP_W-1:0];
            pwsd_pkg::CSR_TIMEOUT_US:  timeout_in = csr_wr.data;
            default: ;
         endcase
      end
   end

   // Bit decision: threshold wraps to 8 bits
   always_comb begin
      count_inc = (count_ff == pwsd_pkg::COUNT_MAX) ? count_ff : count_ff + 1'b1;
      if (count_inc == pwsd_pkg::STOP_EDGE)
         thr = strobe_ff + (strobe_ff >> 1);
      else if (shift_ff[0])
         thr = strobe_ff + strobe_ff;
      else
         thr = strobe_ff;
      bit_early = delta < pwsd_pkg::TIME_W'(thr);
      shifted   = {shift_ff[pwsd_pkg::WORD_W-2:0], bit_early};
   end

   // Even parity over bits 9..0 and over bits 15..10 of the word
   assign parity_bad = (^ready_ff[9:0]) || (^ready_ff[15:10]);

   // Edge and poll state update
   always_comb begin
      last_in    = last_ff;
      count_in   = count_ff;
      strobe_in  = strobe_ff;
      shift_in   = shift_ff;
      ready_in   = ready_ff;
      poll_valid = is_poll;
      poll.range  = range_ff;
      poll.code   = {ready_ff[13:11], ready_ff[8:1]};
      poll.status = pwsd_pkg::ST_OK;

      if (is_edge) begin
         last_in = time_us;
         if (delta > pwsd_pkg::TIME_W'(gap_ff)) begin
            count_in = '0;
            shift_in = '0;
         end else begin
            count_in = count_inc;
            if (count_inc == pwsd_pkg::STROBE_EDGE) begin
               strobe_in = delta[pwsd_pkg::STROBE_W:1];
            end else begin
               shift_in = shifted;
               if (count_inc == pwsd_pkg::LATCH_EDGE)
                  ready_in = shifted;
            end
         end
      end

      if (delta > timeout_ff) begin
         poll.status = pwsd_pkg::ST_LOST;
      end else if (ready_ff == '0) begin
         poll.status = pwsd_pkg::ST_NONE;
      end else begin
         poll.status = parity_bad ? pwsd_pkg::ST_PARITY : pwsd_pkg::ST_OK;
         if (is_poll)
            ready_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff   <= 1'b0;
         gap_ff     <= pwsd_pkg::GAP_RESET;
         timeout_ff <= pwsd_pkg::TIMEOUT_RESET;
         last_ff    <= '0;
         count_ff   <= '0;
         strobe_ff  <= '0;
         shift_ff   <= '0;
         ready_ff   <= '0;
      end else begin
         range_ff   <= range_in;
         gap_ff     <= gap_in;
         timeout_ff <= timeout_in;
         last_ff    <= last_in;
         count_ff   <= count_in;
         strobe_ff  <= strobe_in;
         shift_ff   <= shift_in;
         ready_ff   <= ready_in;
      end
   end

`ifndef SYNTH
   // A poll that takes the word leaves nothing latched behind
   a_word_taken: assert property (@(posedge clock) disable iff (reset)
      is_poll && (poll.status == pwsd_pkg::ST_OK || poll.status == pwsd_pkg::ST_PARITY)
      |=> ready_ff == '0)
      else $error("latched word not cleared after poll");

   // A lost-signal poll keeps the latched word
   a_word_kept: assert property (@(posedge clock) disable iff (reset)
      is_poll && poll.status == pwsd_pkg::ST_LOST |=> $stable(ready_ff))
      else $error("latched word changed on lost-signal poll");

   // A long gap restarts the frame
   a_gap_restart: assert property (@(posedge clock) disable iff (reset)
      is_edge && (delta > pwsd_pkg::TIME_W'(gap_ff)) |=> count_ff == '0)
      else $error("edge count not cleared after a long gap");
`endif

endmodule

@@ rtl/core/pwsd_conv.sv @@
// Conversion pipeline: scales the 11-bit sensor code to Q8 degrees with a
// rounded divide by 2047, and holds the response register. Depends on pwsd_pkg.
module pwsd_conv (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  pwsd_pkg::poll_type                 in_poll,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [1:0]                         out_status,
   output logic signed [pwsd_pkg::TEMP_W-1:0] out_temp
);

   // Stage valids
   logic s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in, out_v_ff, out_v_in;
   logic s1_adv, s2_adv, s3_adv, out_free, s3_free, s2_free, s1_free;

   // Payload
   pwsd_pkg::poll_type                s1_ff;
   pwsd_pkg::status_type              s2_st_ff, s3_st_ff, out_st_ff;
   logic                              s2_rng_ff, s3_rng_ff;
   logic [pwsd_pkg::PROD_W-1:0]       s2_y_ff, s2_y_in, s3_y_ff;
   logic [pwsd_pkg::QUOT_W-1:0]       s3_est_ff, s3_est_in;
   logic [pwsd_pkg::TEMP_W-1:0]       out_temp_ff, out_temp_in;

   logic [pwsd_pkg::PROD_W-1:0]       span;
   logic [pwsd_pkg::SUM_W-1:0]        est_sum;
   logic [pwsd_pkg::SUM_W-1:0]        est_prod;
   logic [pwsd_pkg::SUM_W-1:0]        rem;
   logic [pwsd_pkg::QUOT_W-1:0]       quot;
   logic [pwsd_pkg::TEMP_W-1:0]       offset;

   // Bubble-collapsing advance, from the output back
   assign out_free = !out_v_ff || out_ready;
   assign s3_adv   = s3_v_ff && out_free;
   assign s3_free  = !s3_v_ff || s3_adv;
   assign s2_adv   = s2_v_ff && s3_free;
   assign s2_free  = !s2_v_ff || s2_adv;
   assign s1_adv   = s1_v_ff && s2_free;
   assign s1_free  = !s1_v_ff || s1_adv;
   assign in_ready = s1_free;

   assign s1_v_in  = (s1_v_ff && !s1_adv) || (in_valid && s1_free);
   assign s2_v_in  = (s2_v_ff && !s2_adv) || s1_adv;
   assign s3_v_in  = (s3_v_ff && !s3_adv) || s2_adv;
   assign out_v_in = (out_v_ff && !out_ready) || s3_adv;

   // Stage 1: code times span plus half the divisor
   assign span    = s1_ff.range ? pwsd_pkg::PROD_W'(pwsd_pkg::SPAN_NAR)
                                : pwsd_pkg::PROD_W'(pwsd_pkg::SPAN_WIDE);
   assign s2_y_in = pwsd_pkg::PROD_W'(s1_ff.code) * span
                  + pwsd_pkg::PROD_W'(pwsd_pkg::HALF_SCALE);

   // Stage 2: y/2047 estimate from y/2048 * (1 + 2^-11 + 2^-22), low by at most one
   assign est_sum   = pwsd_pkg::SUM_W'(s2_y_ff) + pwsd_pkg::SUM_W'(s2_y_ff >> 11)
                    + pwsd_pkg::SUM_W'(s2_y_ff >> 22);
   assign s3_est_in = est_sum[pwsd_pkg::QUOT_W+10:11];

   // Stage 3: one correction step, then the offset
   assign est_prod = pwsd_pkg::SUM_W'({s3_est_ff, 11'b0}) - pwsd_pkg::SUM_W'(s3_est_ff);
   assign rem      = pwsd_pkg::SUM_W'(s3_y_ff) - est_prod;
   assign quot     = s3_est_ff
                   + pwsd_pkg::QUOT_W'(rem >= pwsd_pkg::SUM_W'(pwsd_pkg::FULL_SCALE));
   assign offset   = s3_rng_ff ? pwsd_pkg::TEMP_W'(pwsd_pkg::OFF_NAR)
                               : pwsd_pkg::TEMP_W'(pwsd_pkg::OFF_WIDE);
   assign out_temp_in = (s3_st_ff == pwsd_pkg::ST_OK)
                      ? pwsd_pkg::TEMP_W'(quot) - offset : '0;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_valid && s1_free) begin
         s1_ff <= in_poll;
      end
      if (s1_adv) begin
         s2_st_ff  <= s1_ff.status;
         s2_rng_ff <= s1_ff.range;
         s2_y_ff   <= s2_y_in;
      end
      if (s2_adv) begin
         s3_st_ff  <= s2_st_ff;
         s3_rng_ff <= s2_rng_ff;
         s3_y_ff   <= s2_y_ff;
         s3_est_ff <= s3_est_in;
      end
      if (s3_adv) begin
         out_st_ff   <= s3_st_ff;
         out_temp_ff <= out_temp_in;
      end
   end

   assign out_valid  = out_v_ff;
   assign out_status = out_st_ff;
   assign out_temp   = $signed(out_temp_ff);

`ifndef SYNTH
   // Temperature is zero unless the status is ok
   a_temp_zero: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_st_ff != pwsd_pkg::ST_OK |-> out_temp_ff == '0)
      else $error("nonzero temperature on non-ok status");

   // Input is held off only when every stage is occupied
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> s1_v_ff && s2_v_ff && s3_v_ff && out_v_ff && !out_ready)
      else $error("input stalled with a free stage");

   // Ok results stay in the wide scale's range
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_st_ff == pwsd_pkg::ST_OK
      |-> $signed(out_temp_ff) >= -17'sd12800 && $signed(out_temp_ff) <= 17'sd38400)
      else $error("temperature out of range");
`endif

endmodule

@@ rtl/core/pulse_width_sensor_decoder.sv @@
// Top level of the pulse-width sensor decoder: tracker and conversion pipeline.
// Depends on pwsd_pkg, pwsd_if, pwsd_track and pwsd_conv.
//
//   channel    dir  handshake       payload
//   req_chan   in   valid/ready     kind, time_us
//   rsp_chan   out  valid/ready     status, temperature_q8 (one per poll)
//   csr_chan   in   valid/ready     index, data (always ready)
//
// One transaction per cycle while req_chan.ready is high. Edges and polls update
// the tracker state in the cycle they are accepted; a poll's response passes
// through the input register, the scale multiply, the divide-by-2047 estimate
// and its correction into the response register. The pipeline collapses bubbles,
// so requests keep flowing while a response waits; req_chan.ready drops only
// when all four stages are full and stalled.
// Reset is synchronous and restores the register defaults and an empty frame.
module pulse_width_sensor_decoder (
   input  logic     clock,
   input  logic     reset,
   pwsd_req_if.sink   req_chan,
   pwsd_rsp_if.source rsp_chan,
   pwsd_csr_if.sink   csr_chan
);

   pwsd_pkg::csr_write_type csr_wr;
   pwsd_pkg::poll_type      poll;
   logic                    poll_valid;
   logic                    accept;
   logic                    conv_ready;

   // Register writes are always taken
   assign csr_chan.ready = 1'b1;
   assign csr_wr.valid   = csr_chan.valid;
   assign csr_wr.index   = csr_chan.index;
   assign csr_wr.data    = csr_chan.data;

   assign req_chan.ready = conv_ready;
   assign accept         = req_chan.valid && conv_ready;

   pwsd_track u_track (
      .clock      (clock),
      .reset      (reset),
      .csr_wr     (csr_wr),
      .accept     (accept),
      .kind       (req_chan.kind),
      .time_us    (req_chan.time_us),
      .poll_valid (poll_valid),
      .poll       (poll)
   );

   pwsd_conv u_conv (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (poll_valid),
      .in_ready   (conv_ready),
      .in_poll    (poll),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_status (rsp_chan.status),
      .out_temp   (rsp_chan.temperature_q8)
   );

endmodule

@@ dv/pulse_width_sensor_decoder_tb.sv @@
// Self-checking testbench for pulse_width_sensor_decoder: directed table, then random frames.
// Keeps its own decoder state and checks every reading against it.
// Depends on pwsd_pkg, the channel interfaces in pwsd_if and the decoder RTL.
`timescale 1ns / 100ps

module pulse_width_sensor_decoder_tb;

   localparam int CYCLE_LIMIT     = 800_000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 210;
   localparam int SETTLE_CYCLES   = 8;
   localparam int MAX_REPORTS     = 10;

   // Register slot past the end of the map, writes to it must be dropped
   localparam logic [pwsd_pkg::CSR_IDX_W-1:0] CSR_UNUSED = pwsd_pkg::CSR_IDX_W'(3);

   typedef struct packed {
      pwsd_pkg::status_type                 status;
      logic signed [pwsd_pkg::TEMP_W-1:0]   temp;
   } reading_type;

   // Directed table operations
   typedef enum logic [1:0] {
      ROW_POLL  = 2'd0,
      ROW_EDGE  = 2'd1,
      ROW_FRAME = 2'd2,
      ROW_CSR   = 2'd3
   } row_op_type;

   // arg: time step, word or register index; aux: strobe, edge count or data
   typedef struct packed {
      row_op_type                           op;
      logic [31:0]                          arg;
      logic [31:0]                          aux;
      logic                                 typed;
      pwsd_pkg::status_type                 status;
      logic signed [pwsd_pkg::TEMP_W-1:0]   temp;
   } plan_row_type;

   logic clock;
   logic reset;

   pwsd_req_if req_chan ();
   pwsd_rsp_if rsp_chan ();
   pwsd_csr_if csr_chan ();

   pulse_width_sensor_decoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Decoder state as the testbench sees it
   logic                           m_range;
   logic [pwsd_pkg::GAP_W-1:0]     m_gap;
   logic [pwsd_pkg::TIME_W-1:0]    m_timeout;
   logic [pwsd_pkg::TIME_W-1:0]    m_last;
   logic [pwsd_pkg::COUNT_W-1:0]   m_count;
   logic [pwsd_pkg::STROBE_W-1:0]  m_strobe;
   logic [pwsd_pkg::WORD_W-1:0]    m_shift;
   logic [pwsd_pkg::WORD_W-1:0]    m_ready;

   reading_type    pending_readings [$];
   plan_row_type   plan [$];
   logic [31:0]    cur_time;
   int             items_sent;
   int             error_count;
   int             cycles_run;
   bit             calm;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $time, what);
      end
   endtask

   // Bit threshold for the edge that brings the count to cnt
   function automatic logic [pwsd_pkg::STROBE_W-1:0] edge_threshold(
      input logic [pwsd_pkg::COUNT_W-1:0] cnt);
      logic [pwsd_pkg::STROBE_W-1:0] thr;
      thr = m_strobe;
      if (cnt == pwsd_pkg::STOP_EDGE) begin
         thr = thr + (m_strobe >> 1);
      end else if (m_shift[0]) begin
         thr = thr + m_strobe;
      end
      return thr;
   endfunction

   // Q8 degrees from the 11-bit code packed in the word, rounded to nearest
   function automatic logic signed [pwsd_pkg::TEMP_W-1:0] scale_q8(
      input logic [pwsd_pkg::WORD_W-1:0] w);
      int code;
      int span;
      int offset;
      int scaled;
      code   = int'({w[13:11], w[8:1]});
      span   = m_range ? pwsd_pkg::SPAN_NAR : pwsd_pkg::SPAN_WIDE;
      offset = m_range ? pwsd_pkg::OFF_NAR : pwsd_pkg::OFF_WIDE;
      scaled = (2 * code * span + pwsd_pkg::FULL_SCALE) / (2 * pwsd_pkg::FULL_SCALE) - offset;
      return scaled[pwsd_pkg::TEMP_W-1:0];
   endfunction

   // Apply one accepted transaction; returns 1 when it produces a reading
   function automatic bit track_event(input logic kind, input logic [pwsd_pkg::TIME_W-1:0] t,
                                      output reading_type rd);
      logic [pwsd_pkg::TIME_W-1:0]   delta;
      logic [pwsd_pkg::WORD_W-1:0]   w;
      logic [pwsd_pkg::STROBE_W-1:0] thr;
      delta     = t - m_last;
      rd.status = pwsd_pkg::ST_OK;
      rd.temp   = '0;
      if (kind == pwsd_pkg::KIND_EDGE) begin
         m_last = t;
         // long gap: new frame
         if (delta > m_gap) begin
            m_count = '0;
            m_shift = '0;
            return 1'b0;
         end
         if (m_count != pwsd_pkg::COUNT_MAX) m_count++;
         if (m_count == pwsd_pkg::STROBE_EDGE) begin
            m_strobe = delta[pwsd_pkg::STROBE_W:1];
            return 1'b0;
         end
         thr     = edge_threshold(m_count);
         m_shift = {m_shift[pwsd_pkg::WORD_W-2:0], delta < thr};
         if (m_count == pwsd_pkg::LATCH_EDGE) m_ready = m_shift;
         return 1'b0;
      end
      // poll
      if (delta > m_timeout) begin
         rd.status = pwsd_pkg::ST_LOST;
      end else if (m_ready == '0) begin
         rd.status = pwsd_pkg::ST_NONE;
      end else begin
         w       = m_ready;
         m_ready = '0;
         if ((^w[9:0]) || (^w[15:10])) begin
            rd.status = pwsd_pkg::ST_PARITY;
         end else begin
            rd.temp = scale_q8(w);
         end
      end
      return 1'b1;
   endfunction

   function automatic int pick_idle();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic int pick_strobe();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(40, 170);
      if (roll < 90) return $urandom_range(171, 511);
      return $urandom_range(0, 39);
   endfunction

   function automatic plan_row_type make_row(input row_op_type op, input logic [31:0] arg,
                                             input logic [31:0] aux, input logic typed,
                                             input pwsd_pkg::status_type status,
                                             input int temp);
      plan_row_type r;
      r.op     = op;
      r.arg    = arg;
      r.aux    = aux;
      r.typed  = typed;
      r.status = status;
      r.temp   = temp[pwsd_pkg::TEMP_W-1:0];
      return r;
   endfunction

   // One request transaction at cur_time + step; a typed reading overrides the prediction
   task automatic send_item(input logic kind, input logic [31:0] step, input logic typed,
                            input pwsd_pkg::status_type status,
                            input logic signed [pwsd_pkg::TEMP_W-1:0] temp);
      int          idle;
      reading_type rd;
      idle     = pick_idle();
      cur_time = cur_time + step;
      repeat (idle) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.kind    <= kind;
      req_chan.time_us <= cur_time;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (track_event(kind, cur_time, rd)) begin
         if (typed) begin
            rd.status = status;
            rd.temp   = temp;
         end
         pending_readings.push_back(rd);
      end
      items_sent++;
   endtask

   // Start edge, strobe edge, then n_edges-1 data edges aimed at the word
   task automatic send_frame(input logic [pwsd_pkg::WORD_W-1:0] word, input int strobe,
                             input int n_edges);
      int                            k;
      logic [pwsd_pkg::COUNT_W-1:0]  next_count;
      logic [pwsd_pkg::STROBE_W-1:0] thr;
      logic [31:0]                   d;
      logic                          one;
      send_item(pwsd_pkg::KIND_EDGE, {16'b0, m_gap} + 1 + $urandom_range(0, 2000), 1'b0,
                pwsd_pkg::ST_OK, '0);
      for (k = 1; k <= n_edges; k++) begin
         if (k == 1) begin
            d = strobe;
         end else begin
            next_count = (m_count == pwsd_pkg::COUNT_MAX) ? m_count : m_count + 1'b1;
            thr        = edge_threshold(next_count);
            // edges 4..19 carry word bits 15..0, the rest are filler
            one = (k >= 4 && k <= 19) ? word[19-k] : 1'($urandom_range(0, 1));
            if (one) begin
               d = (thr == '0) ? 32'd0 : $urandom_range(0, thr - 1);
            end else begin
               d = {24'b0, thr} + $urandom_range(0, m_strobe);
            end
            if (d > m_gap) d = {16'b0, m_gap};
         end
         send_item(pwsd_pkg::KIND_EDGE, d, 1'b0, pwsd_pkg::ST_OK, '0);
      end
   endtask

   // Stop requests and let every reading drain before touching registers
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [pwsd_pkg::CSR_IDX_W-1:0] index,
                            input logic [31:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      case (index)
         pwsd_pkg::CSR_MODEL_RANGE: m_range   = data[0];
         pwsd_pkg::CSR_GAP_US:      m_gap     = data[pwsd_pkg::GAP_W-1:0];
         pwsd_pkg::CSR_TIMEOUT_US:  m_timeout = data;
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // One random sequence: mostly clean frames, otherwise broken frames, polls and noise
   task automatic random_sequence();
      int                          roll;
      int                          pick;
      int                          n;
      logic [pwsd_pkg::WORD_W-1:0] word;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 2);
      if (roll < 60) begin
         word = pwsd_pkg::WORD_W'($urandom);
         if ($urandom_range(0, 4) != 0) begin
            word[0]  = ^word[9:1];
            word[10] = ^word[15:11];
         end
         if ($urandom_range(0, 40) == 0) word = '0;
         send_frame(word, pick_strobe(), 19);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 1;
         repeat (n) begin
            send_item(pwsd_pkg::KIND_POLL,
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300),
                      1'b0, pwsd_pkg::ST_OK, '0);
         end
      end else if (roll < 70) begin
         // truncated or overlong frame
         n = $urandom_range(0, 1) ? $urandom_range(0, 18) : $urandom_range(20, 40);
         send_frame(pwsd_pkg::WORD_W'($urandom), pick_strobe(), n);
         if ($urandom_range(0, 1)) begin
            send_item(pwsd_pkg::KIND_POLL, $urandom_range(0, 300), 1'b0, pwsd_pkg::ST_OK, '0);
         end
      end else if (roll < 82) begin
         if (pick == 1) cur_time = m_last + m_timeout - 1 + $urandom_range(0, 2);
         if (pick == 2) cur_time = $urandom;
         send_item(pwsd_pkg::KIND_POLL, (pick == 0) ? $urandom_range(0, 500) : 0, 1'b0,
                   pwsd_pkg::ST_OK, '0);
      end else if (roll < 94) begin
         if (pick == 1) cur_time = m_last + m_gap + $urandom_range(0, 1);
         if (pick == 2) cur_time = $urandom;
         send_item(pwsd_pkg::KIND_EDGE, (pick == 0) ? $urandom_range(0, 300) : 0, 1'b0,
                   pwsd_pkg::ST_OK, '0);
      end else begin
         repeat ($urandom_range(5, 25)) begin
            send_item(pwsd_pkg::KIND_EDGE, $urandom_range(0, 200), 1'b0, pwsd_pkg::ST_OK, '0);
         end
      end
   endtask

   // Response ready: random stalls, mostly short, none in calm phases
   always @(negedge clock) begin : rsp_pacing
      int roll;
      int hold;
      if (calm) begin
         rsp_chan.ready <= 1'b1;
      end else if (hold > 0) begin
         hold = hold - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            hold = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(5, 40);
            rsp_chan.ready <= 1'b0;
         end
      end
   end

   // Compare each response transaction with the oldest pending reading
   always @(posedge clock) begin : reading_check
      reading_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_readings.size() == 0) begin
            flag_error($sformatf("unexpected reading: status %0d temp %0d",
                                 rsp_chan.status, rsp_chan.temperature_q8));
         end else begin
            want = pending_readings.pop_front();
            if (rsp_chan.status !== want.status || rsp_chan.temperature_q8 !== want.temp) begin
               flag_error($sformatf("expected status %0d temp %0d, got status %0d temp %0d",
                                    want.status, $signed(want.temp),
                                    rsp_chan.status, rsp_chan.temperature_q8));
            end
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      int                i;
      int                phase;
      int                phase_start;
      logic [31:0]       range_v;
      logic [31:0]       gap_v;
      logic [31:0]       timeout_v;

      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.kind    = pwsd_pkg::KIND_EDGE;
      req_chan.time_us = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = pwsd_pkg::CSR_MODEL_RANGE;
      csr_chan.data    = '0;
      calm             = 1'b0;
      error_count      = 0;
      items_sent       = 0;
      cur_time         = '0;
      m_range          = 1'b0;
      m_gap            = pwsd_pkg::GAP_RESET;
      m_timeout        = pwsd_pkg::TIMEOUT_RESET;
      m_last           = '0;
      m_count          = '0;
      m_strobe         = '0;
      m_shift          = '0;
      m_ready          = '0;

      // Directed plan; typed readings where the value is obvious
      plan.push_back(make_row(ROW_POLL,  0,        0,   1'b1, pwsd_pkg::ST_NONE,   0));
      plan.push_back(make_row(ROW_POLL,  100001,   0,   1'b1, pwsd_pkg::ST_LOST,   0));
      plan.push_back(make_row(ROW_FRAME, 32'h3DFE, 100, 1'b0, pwsd_pkg::ST_OK,     0));
      plan.push_back(make_row(ROW_POLL,  10,       0,   1'b1, pwsd_pkg::ST_OK,     38400));
      plan.push_back(make_row(ROW_POLL,  10,       0,   1'b1, pwsd_pkg::ST_NONE,   0));
      // lost signal keeps the word for a later poll
      plan.push_back(make_row(ROW_FRAME, 32'hC201, 100, 1'b0, pwsd_pkg::ST_OK,     0));
      plan.push_back(make_row(ROW_POLL,  200000,   0,   1'b1, pwsd_pkg::ST_LOST,   0));
      plan.push_back(make_row(ROW_EDGE,  1000,     1,   1'b0, pwsd_pkg::ST_OK,     0));
      plan.push_back(make_row(ROW_POLL,  5,        0,   1'b1, pwsd_pkg::ST_OK,     -12800));
      plan.push_back(make_row(ROW_FRAME, 32'h0001, 100, 1'b0, pwsd_pkg::ST_OK,     0));
      plan.push_back(make_row(ROW_POLL,  5,        0,   1'b1, pwsd_pkg::ST_PARITY, 0));
      plan.push_back(make_row(ROW_FRAME, 32'h0000, 100, 1'b0, pwsd_pkg::ST_OK,     0));
      plan.push_back(make_row(ROW_POLL,  5,        0,   1'b1, pwsd_pkg::ST_NONE,   0));
      // edge count saturation, no second latch
      plan.push_back(make_row(ROW_FRAME, 32'h5A5A, 90,  1'b0, pwsd_pkg::ST_OK,     0));
      plan.push_back(make_row(ROW_EDGE,  20,       15,  1'b0, pwsd_pkg::ST_OK,     0));
      plan.push_back(make_row(ROW_POLL,  5,        0,   1'b0, pwsd_pkg::ST_OK,     0));
      // widest gap (upper data bits masked), strobe too big for 8 bits
      plan.push_back(make_row(ROW_CSR, 32'(pwsd_pkg::CSR_GAP_US), 32'h1234FFFF, 1'b0,
                              pwsd_pkg::ST_OK, 0));
      plan.push_back(make_row(ROW_FRAME, 32'h3DFE, 510, 1'b0, pwsd_pkg::ST_OK,     0));
      plan.push_back(make_row(ROW_POLL,  5,        0,   1'b0, pwsd_pkg::ST_OK,     0));
      // unmapped index dropped, narrow scale
      plan.push_back(make_row(ROW_CSR, 32'(CSR_UNUSED), 32'hFFFFFFFF, 1'b0,
                              pwsd_pkg::ST_OK, 0));
      plan.push_back(make_row(ROW_CSR, 32'(pwsd_pkg::CSR_MODEL_RANGE), 32'hFFFFFFFF, 1'b0,
                              pwsd_pkg::ST_OK, 0));
      plan.push_back(make_row(ROW_FRAME, 32'h3DFE, 100, 1'b0, pwsd_pkg::ST_OK,     0));
      plan.push_back(make_row(ROW_POLL,  5,        0,   1'b1, pwsd_pkg::ST_OK,     15360));
      plan.push_back(make_row(ROW_FRAME, 32'hC201, 100, 1'b0, pwsd_pkg::ST_OK,     0));
      plan.push_back(make_row(ROW_POLL,  5,        0,   1'b1, pwsd_pkg::ST_OK,     -2560));
      // timeout extremes
      plan.push_back(make_row(ROW_CSR, 32'(pwsd_pkg::CSR_TIMEOUT_US), 0, 1'b0,
                              pwsd_pkg::ST_OK, 0));
      plan.push_back(make_row(ROW_EDGE,  10,       1,   1'b0, pwsd_pkg::ST_OK,     0));
      plan.push_back(make_row(ROW_POLL,  0,        0,   1'b1, pwsd_pkg::ST_NONE,   0));
      plan.push_back(make_row(ROW_POLL,  1,        0,   1'b1, pwsd_pkg::ST_LOST,   0));
      plan.push_back(make_row(ROW_CSR, 32'(pwsd_pkg::CSR_TIMEOUT_US), 32'hFFFFFFFF, 1'b0,
                              pwsd_pkg::ST_OK, 0));
      plan.push_back(make_row(ROW_POLL, 32'h80000000, 0, 1'b1, pwsd_pkg::ST_NONE,  0));

      // Synchronous reset
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part
      for (i = 0; i < plan.size(); i++) begin
         case (plan[i].op)
            ROW_POLL: send_item(pwsd_pkg::KIND_POLL, plan[i].arg, plan[i].typed,
                                plan[i].status, plan[i].temp);
            ROW_EDGE: begin
               repeat (plan[i].aux) begin
                  send_item(pwsd_pkg::KIND_EDGE, plan[i].arg, 1'b0, pwsd_pkg::ST_OK, '0);
               end
            end
            ROW_FRAME: send_frame(plan[i].arg[pwsd_pkg::WORD_W-1:0], plan[i].aux, 19);
            ROW_CSR: begin
               settle();
               write_reg(plan[i].arg[pwsd_pkg::CSR_IDX_W-1:0], plan[i].aux);
            end
            default: ;
         endcase
      end

      // Random phases, each with its own register setting
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         calm      = (phase % 4 == 3);
         range_v   = $urandom;
         gap_v     = ($urandom & 32'hFFFF_0000) | $urandom_range(150, 3000);
         timeout_v = $urandom_range(500, 300000);
         if (phase == 1) begin
            range_v[0]                  = 1'b0;
            gap_v[pwsd_pkg::GAP_W-1:0]  = '0;
            timeout_v                   = '0;
         end
         if (phase == 2) begin
            range_v[0]                  = 1'b1;
            gap_v[pwsd_pkg::GAP_W-1:0]  = '1;
            timeout_v                   = '1;
         end
         write_reg(pwsd_pkg::CSR_MODEL_RANGE, range_v);
         write_reg(pwsd_pkg::CSR_GAP_US, gap_v);
         write_reg(pwsd_pkg::CSR_TIMEOUT_US, timeout_v);
         if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED, $urandom);
         phase_start = items_sent;
         while (items_sent - phase_start < ITEMS_PER_PHASE) random_sequence();
      end

      // Drain and report
      settle();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/pwsd_pkg.sv
rtl/core/pwsd_if.sv
rtl/core/pwsd_track.sv
rtl/core/pwsd_conv.sv
rtl/core/pulse_width_sensor_decoder.sv
dv/pulse_width_sensor_decoder_tb.sv
